[design/hfu_pkg.sv]
// shared types and constants for the hermitian unpack address sequencer
package hfu_pkg;

  // flat element index width on the result side
  localparam int IDX_W = 30;

  // configuration port
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 2;

  // stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 1;

  // cycles the derived products need to settle after a size write
  localparam int SETTLE_W      = 2;
  localparam int SETTLE_CYCLES = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_SIZE_X = 2'd0;
  localparam cfg_idx_t REG_SIZE_Y = 2'd1;
  localparam cfg_idx_t REG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1;

  // control from the configuration block to the walker
  typedef struct packed {
    logic abort;
    logic busy;
  } hfu_ctl_t;

endpackage

[design/hfu_cfg.sv]
// size registers, clamping and the precomputed row and plane strides
module hfu_cfg #(
  parameter int MAX_DIM = 1024,
  localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfu_pkg::SIZE_W-1:0]     cfg_data,
  output logic [DIM_W-1:0]               dim_x,
  output logic [DIM_W-1:0]               dim_y,
  output logic [DIM_W-1:0]               dim_z,
  output logic [DIM_W-1:0]               start_x,
  output logic [hfu_pkg::IDX_W-1:0]      plane,
  output logic [hfu_pkg::IDX_W-1:0]      y_last_off,
  output logic [hfu_pkg::IDX_W-1:0]      z_last_off,
  output hfu_pkg::hfu_ctl_t              ctl
);
  import hfu_pkg::*;

  localparam int PLANE_W = 2 * DIM_W;
  localparam int ZPROD_W = DIM_W + PLANE_W;

  logic [SIZE_W-1:0]   size_x_r, size_y_r, size_z_r;
  logic [DIM_W-1:0]    eff_x, eff_y, eff_z;
  logic [DIM_W-1:0]    nx_r, ny_r, nz_r, start_r;
  logic [PLANE_W-1:0]  plane_full, ylast_full;
  logic [PLANE_W-1:0]  plane_r, ylast_r;
  logic [ZPROD_W-1:0]  zlast_full;
  logic [ZPROD_W-1:0]  zlast_r;
  logic [SETTLE_W-1:0] settle_r;
  logic                cfg_beat;
  logic                size_write;

  // zero reads as one, anything above the limit reads as the limit
  function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > SIZE_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return v[DIM_W-1:0];
    end
  endfunction

  assign cfg_ready  = 1'b1;
  assign cfg_beat   = cfg_valid & cfg_ready;
  assign size_write = cfg_beat &&
                      (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                       cfg_index == REG_SIZE_Z);

  // raw size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_beat) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_x = eff_size(size_x_r);
  assign eff_y = eff_size(size_y_r);
  assign eff_z = eff_size(size_z_r);

  // first product stage: x*y plane and the stride to the mirrored y=1 row
  assign plane_full = {{DIM_W{1'b0}}, eff_x} * {{DIM_W{1'b0}}, eff_y};
  assign ylast_full = {{DIM_W{1'b0}}, eff_y - DIM_W'(1)} * {{DIM_W{1'b0}}, eff_x};

  always_ff @(posedge clk) begin
    nx_r    <= eff_x;
    ny_r    <= eff_y;
    nz_r    <= eff_z;
    start_r <= {1'b0, eff_x[DIM_W-1:1]} + DIM_W'(1);
    plane_r <= plane_full;
    ylast_r <= ylast_full;
  end

  // second product stage: offset of the mirrored z=1 plane
  assign zlast_full = {{PLANE_W{1'b0}}, nz_r - DIM_W'(1)} * {{DIM_W{1'b0}}, plane_r};

  always_ff @(posedge clk) begin
    zlast_r <= zlast_full;
  end

  // hold off items until both product stages carry the new sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (cfg_beat) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SETTLE_W'(1);
    end
  end

  assign dim_x      = nx_r;
  assign dim_y      = ny_r;
  assign dim_z      = nz_r;
  assign start_x    = start_r;
  assign plane      = IDX_W'(plane_r);
  assign y_last_off = IDX_W'(ylast_r);
  assign z_last_off = IDX_W'(zlast_r);
  assign ctl.abort  = size_write;
  assign ctl.busy   = (settle_r != '0);

endmodule

[design/hfu_walk.sv]
// position counters, incremental row offsets and the result register
module hfu_walk #(
  parameter int MAX_DIM = 1024,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int POS_W = $clog2(MAX_DIM)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hfu_pkg::hfu_ctl_t         ctl,
  input  logic [DIM_W-1:0]          dim_x,
  input  logic [DIM_W-1:0]          dim_y,
  input  logic [DIM_W-1:0]          dim_z,
  input  logic [DIM_W-1:0]          start_x,
  input  logic [hfu_pkg::IDX_W-1:0] plane,
  input  logic [hfu_pkg::IDX_W-1:0] y_last_off,
  input  logic [hfu_pkg::IDX_W-1:0] z_last_off,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hfu_pkg::IDX_W-1:0] src_index,
  output logic [hfu_pkg::IDX_W-1:0] dst_index,
  output logic                      pair_valid,
  output logic                      last_pair
);
  import hfu_pkg::*;

  logic [POS_W-1:0] px_r, py_r, pz_r;
  logic             fin_r;
  logic [IDX_W-1:0] drow_r, zbase_r, srow_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] src_r, dst_r;
  logic             pv_r, last_r;

  logic             in_beat;
  logic [DIM_W-1:0] cx, cy, cz;
  logic             cfin;
  logic [IDX_W-1:0] cdrow, czbase, csrow;
  logic [IDX_W-1:0] src_calc, dst_calc;
  logic             x_end, y_end, z_end;

  logic [DIM_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic             fin_nxt;
  logic [IDX_W-1:0] drow_nxt, zbase_nxt, srow_nxt;

  assign in_ready = !ctl.busy && (!out_valid_r || out_ready);
  assign in_beat  = in_valid & in_ready;

  // current position: a restart starts over at the first pair
  always_comb begin
    if (restart) begin
      cx     = start_x;
      cy     = '0;
      cz     = '0;
      cfin   = (start_x >= dim_x);
      cdrow  = '0;
      czbase = '0;
      csrow  = '0;
    end else begin
      cx     = DIM_W'(px_r);
      cy     = DIM_W'(py_r);
      cz     = DIM_W'(pz_r);
      cfin   = fin_r;
      cdrow  = drow_r;
      czbase = zbase_r;
      csrow  = srow_r;
    end
  end

  // flat indexes from the row offsets
  assign src_calc = csrow + IDX_W'(dim_x - cx);
  assign dst_calc = cdrow + IDX_W'(cx);
  assign x_end    = (cx == dim_x - DIM_W'(1));
  assign y_end    = (cy == dim_y - DIM_W'(1));
  assign z_end    = (cz == dim_z - DIM_W'(1));

  // advance x, then y, then z; offsets step by a stride at each row change
  always_comb begin
    px_nxt    = cx + DIM_W'(1);
    py_nxt    = cy;
    pz_nxt    = cz;
    fin_nxt   = 1'b0;
    drow_nxt  = cdrow;
    zbase_nxt = czbase;
    srow_nxt  = csrow;
    if (x_end) begin
      px_nxt   = start_x;
      drow_nxt = cdrow + IDX_W'(dim_x);
      if (y_end) begin
        py_nxt    = '0;
        pz_nxt    = z_end ? '0 : cz + DIM_W'(1);
        fin_nxt   = z_end;
        zbase_nxt = (cz == '0) ? z_last_off : czbase - plane;
        srow_nxt  = zbase_nxt;
      end else begin
        py_nxt   = cy + DIM_W'(1);
        srow_nxt = (cy == '0) ? czbase + y_last_off : csrow - IDX_W'(dim_x);
      end
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r    <= POS_W'(1);
      py_r    <= '0;
      pz_r    <= '0;
      fin_r   <= 1'b1;
      drow_r  <= '0;
      zbase_r <= '0;
      srow_r  <= '0;
    end else if (in_beat) begin
      if (cfin) begin
        px_r    <= POS_W'(cx);
        py_r    <= POS_W'(cy);
        pz_r    <= POS_W'(cz);
        fin_r   <= 1'b1;
        drow_r  <= cdrow;
        zbase_r <= czbase;
        srow_r  <= csrow;
      end else begin
        px_r    <= POS_W'(px_nxt);
        py_r    <= POS_W'(py_nxt);
        pz_r    <= POS_W'(pz_nxt);
        fin_r   <= fin_nxt;
        drow_r  <= drow_nxt;
        zbase_r <= zbase_nxt;
        srow_r  <= srow_nxt;
      end
    end else if (ctl.abort) begin
      fin_r <= 1'b1;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, zero once the pass is finished
  always_ff @(posedge clk) begin
    if (in_beat) begin
      src_r  <= cfin ? '0 : src_calc;
      dst_r  <= cfin ? '0 : dst_calc;
      pv_r   <= !cfin;
      last_r <= !cfin && x_end && y_end && z_end;
    end
  end

  assign out_valid  = out_valid_r;
  assign src_index  = src_r;
  assign dst_index  = dst_r;
  assign pair_valid = pv_r;
  assign last_pair  = last_r;

endmodule

[design/hermitian_fft_unpack_address_gen.sv]
// top level of the hermitian-symmetry unpack address sequencer
//
//  channel | direction | beat carries
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | restart flag (1 starts a pass, 0 advances one pair)
//  out_    | master    | src/dst flat indexes, pair valid in tuser, last pair
//  cfg_    | slave     | size_x / size_y / size_z writes by register index
//
// one beat in gives one beat out, one beat per cycle sustained; the walker
// computes a pair from its counters and row offsets combinationally into
// the result register. after reset and after every configuration beat the
// input is held off while the size products settle. beyond that the input
// stalls only while the result register is full and out_tready is low.
module hermitian_fft_unpack_address_gen #(
  parameter int MAX_DIM = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: [0] restart, [7:1] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hfu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tdata: [29:0] src_index, [59:30] dst_index, [63:60] zero
  // tuser: [0] pair_valid
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hfu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [hfu_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hfu_pkg::SIZE_W-1:0]       cfg_data
);
  import hfu_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  hfu_ctl_t         ctl;
  logic [DIM_W-1:0] dim_x, dim_y, dim_z, start_x;
  logic [IDX_W-1:0] plane, y_last_off, z_last_off;
  logic [IDX_W-1:0] src_index, dst_index;
  logic             pair_valid, last_pair;

  // sizes and strides
  hfu_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .dim_x      (dim_x),
    .dim_y      (dim_y),
    .dim_z      (dim_z),
    .start_x    (start_x),
    .plane      (plane),
    .y_last_off (y_last_off),
    .z_last_off (z_last_off),
    .ctl        (ctl)
  );

  // address walk
  hfu_walk #(
    .MAX_DIM (MAX_DIM)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .dim_x      (dim_x),
    .dim_y      (dim_y),
    .dim_z      (dim_z),
    .start_x    (start_x),
    .plane      (plane),
    .y_last_off (y_last_off),
    .z_last_off (z_last_off),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .restart    (in_tdata[0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .src_index  (src_index),
    .dst_index  (dst_index),
    .pair_valid (pair_valid),
    .last_pair  (last_pair)
  );

  // result packing
  assign out_tdata = {{(OUT_TDATA_W - 2 * IDX_W){1'b0}}, dst_index, src_index};
  assign out_tuser = pair_valid;
  assign out_tlast = last_pair;

endmodule

[bench/testbench.sv]
// self-checking bench for the hermitian unpack address sequencer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hfu_pkg::*;

  localparam int MAX_DIM     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_BEATS  = 510;
  localparam int MAX_SHOWN   = 10;
  // index with no register behind it, writes there are ignored
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic             valid;
    logic             last;
  } pair_t;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_idx_t          idx;
    logic [SIZE_W-1:0] value;
    logic              restart;
    logic              typed;
    pair_t             want;
  } plan_row_t;

  localparam pair_t NO_PAIR = '0;
  localparam int PLAN_LEN = 31;

  // directed walk: fixed answers only where they are obvious
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    // idle after reset, then an empty walk at the reset sizes
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b1, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b1, NO_PAIR},
    // size 2 along x has nothing to copy
    '{ROW_CFG,  REG_SIZE_X, 11'd2,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b1, NO_PAIR},
    // size 3: a single pair that is also the last
    '{ROW_CFG,  REG_SIZE_X, 11'd3,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b1, '{30'd1, 30'd2, 1'b1, 1'b1}},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b1, NO_PAIR},
    // zero and over-range sizes are clamped
    '{ROW_CFG,  REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_CFG,  REG_SIZE_Y, 11'd2047, 1'b0, 1'b0, NO_PAIR},
    '{ROW_CFG,  REG_SIZE_Z, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b1, NO_PAIR},
    // small 3d volume
    '{ROW_CFG,  REG_SIZE_X, 11'd6,    1'b0, 1'b0, NO_PAIR},
    '{ROW_CFG,  REG_SIZE_Y, 11'd3,    1'b0, 1'b0, NO_PAIR},
    '{ROW_CFG,  REG_SIZE_Z, 11'd2,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b1, '{30'd2, 30'd4, 1'b1, 1'b0}},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    // restart in the middle of a pass
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b0, NO_PAIR},
    // write to the unused index leaves the pass running
    '{ROW_CFG,  REG_UNUSED, 11'd2047, 1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    // size write aborts the pass
    '{ROW_CFG,  REG_SIZE_Y, 11'd3,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b1, NO_PAIR},
    // largest volume
    '{ROW_CFG,  REG_SIZE_X, 11'd2047, 1'b0, 1'b0, NO_PAIR},
    '{ROW_CFG,  REG_SIZE_Y, 11'd1024, 1'b0, 1'b0, NO_PAIR},
    '{ROW_CFG,  REG_SIZE_Z, 11'd1024, 1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b1, 1'b1, '{30'd511, 30'd513, 1'b1, 1'b0}},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR},
    '{ROW_BEAT, REG_SIZE_X, 11'd0,    1'b0, 1'b0, NO_PAIR}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index;
  logic [SIZE_W-1:0]      cfg_data;

  // mirror of the sequencer state
  logic [SIZE_W-1:0] size_reg [3];
  int unsigned       walk_x, walk_y, walk_z;
  logic              walk_done;

  pair_t pending_pairs [$];
  pair_t fixed_pair;
  logic  fixed_active = 1'b0;
  int    n_errors = 0;
  int    cycle_count = 0;
  int    beats_sent = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  hermitian_fft_unpack_address_gen #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // expected pair for one input beat, advances the mirrored walk
  function automatic pair_t next_pair(input logic restart);
    int unsigned       nx, ny, nz, x0, sy, sz;
    longint unsigned   src_flat, dst_flat;
    pair_t             p;
    nx = clamp_size(size_reg[0]);
    ny = clamp_size(size_reg[1]);
    nz = clamp_size(size_reg[2]);
    x0 = nx / 2 + 1;
    p  = '0;
    if (restart) begin
      walk_x    = x0;
      walk_y    = 0;
      walk_z    = 0;
      walk_done = (x0 >= nx);
    end
    if (walk_done || walk_x >= nx || walk_y >= ny || walk_z >= nz) begin
      walk_done = 1'b1;
      return p;
    end
    // a zero coordinate mirrors onto itself
    sy = (walk_y == 0) ? 0 : ny - walk_y;
    sz = (walk_z == 0) ? 0 : nz - walk_z;
    src_flat = (longint'(sz) * ny + sy) * nx + (nx - walk_x);
    dst_flat = (longint'(walk_z) * ny + walk_y) * nx + walk_x;
    p.src   = src_flat[IDX_W-1:0];
    p.dst   = dst_flat[IDX_W-1:0];
    p.valid = 1'b1;
    p.last  = (walk_x == nx - 1) && (walk_y == ny - 1) && (walk_z == nz - 1);
    // x innermost, then y, then z
    walk_x++;
    if (walk_x >= nx) begin
      walk_x = x0;
      walk_y++;
      if (walk_y >= ny) begin
        walk_y = 0;
        walk_z++;
        if (walk_z >= nz) begin
          walk_z    = 0;
          walk_done = 1'b1;
        end
      end
    end
    return p;
  endfunction

  function automatic void report_mismatch(input string what, input pair_t want,
                                          input pair_t got);
    n_errors++;
    if (n_errors <= MAX_SHOWN) begin
      $display("mismatch (%s) at cycle %0d: expected src=%0d dst=%0d valid=%0b last=%0b",
               what, cycle_count, want.src, want.dst, want.valid, want.last);
      $display("  got src=%0d dst=%0d valid=%0b last=%0b",
               got.src, got.dst, got.valid, got.last);
    end
  endfunction

  // handshake monitor: prediction on input beats, checks on output beats
  always @(posedge clk) begin : monitor
    pair_t got, want;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      cycle_count++;
      if (cfg_valid && cfg_ready && cfg_index != REG_UNUSED) begin
        size_reg[cfg_index] = cfg_data;
        walk_done = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        want = next_pair(in_tdata[0]);
        pending_pairs.push_back(fixed_active ? fixed_pair : want);
      end
      if (out_tvalid && out_tready) begin
        got.src   = out_tdata[IDX_W-1:0];
        got.dst   = out_tdata[2*IDX_W-1:IDX_W];
        got.valid = out_tuser[0];
        got.last  = out_tlast;
        if (pending_pairs.size() == 0) begin
          report_mismatch("no beat expected", NO_PAIR, got);
        end else begin
          want = pending_pairs.pop_front();
          if (got !== want) report_mismatch("field", want, got);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one restart/advance beat, optionally with a fixed expected pair
  task automatic send_beat(input logic restart, input logic typed, input pair_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= {{(IN_TDATA_W-1){1'b0}}, restart};
    fixed_active  = typed;
    fixed_pair    = want;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // stop sending and wait for every expected pair
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(input cfg_idx_t idx, input logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // usually new sizes (mostly small), then a pass with random content
  task automatic random_pass();
    logic [SIZE_W-1:0] pick [3];
    longint unsigned   pairs;
    int unsigned       kind, n_beats, nx;
    logic              noisy, restart;
    kind = $urandom_range(11);
    for (int d = 0; d < 3; d++) begin
      case (kind)
        0, 1: begin
          case ($urandom_range(4))
            0:       pick[d] = 11'd0;
            1:       pick[d] = 11'd1;
            2:       pick[d] = 11'd2;
            3:       pick[d] = 11'd1024;
            default: pick[d] = SIZE_W'($urandom_range(1025, 2047));
          endcase
        end
        2:       pick[d] = (d == 0) ? SIZE_W'($urandom_range(600, 2047))
                                    : SIZE_W'($urandom_range(1, 3));
        default: pick[d] = (d == 0) ? SIZE_W'($urandom_range(1, 14))
                                    : SIZE_W'($urandom_range(1, 4));
      endcase
    end
    // now and then keep the sizes and just restart
    if ($urandom_range(3) != 0) begin
      drain();
      for (int d = 0; d < 3; d++) write_size(cfg_idx_t'(d), pick[d]);
    end
    nx    = clamp_size(size_reg[0]);
    pairs = longint'(nx - nx / 2 - 1) * clamp_size(size_reg[1]) * clamp_size(size_reg[2]);
    n_beats = ((pairs > 48) ? 48 : int'(pairs)) + $urandom_range(0, 3);
    noisy   = ($urandom_range(9) == 0);
    for (int b = 0; b <= n_beats; b++) begin
      if (b == 0) restart = 1'b1;
      else if (noisy) restart = 1'($urandom_range(1));
      else restart = ($urandom_range(39) == 0);
      // now and then the sender holds off until the pipe is empty
      if ($urandom_range(59) == 0) drain();
      send_beat(restart, 1'b0, NO_PAIR);
    end
  endtask

  initial begin : stimulus
    int goal;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SIZE_X;
    cfg_data  = '0;
    for (int d = 0; d < 3; d++) size_reg[d] = SIZE_RESET;
    walk_x    = clamp_size(SIZE_RESET) / 2 + 1;
    walk_y    = 0;
    walk_z    = 0;
    walk_done = 1'b1;
    send_idle_pct  = 35;
    recv_stall_pct = 78;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_CFG) begin
        drain();
        write_size(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].value);
      end else begin
        send_beat(DIRECTED_PLAN[i].restart, DIRECTED_PLAN[i].typed,
                  DIRECTED_PLAN[i].want);
      end
    end

    // random passes under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 35; recv_stall_pct = 78; end
        1:       begin send_idle_pct = 78; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      goal = beats_sent + RAND_BEATS;
      while (beats_sent < goal) random_pass();
    end

    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/hfu_pkg.sv
design/hfu_cfg.sv
design/hfu_walk.sv
design/hermitian_fft_unpack_address_gen.sv
bench/testbench.sv
